// File: design/mme_pkg.sv
// Shared types and constants of the matrix multiply engine.
package mme_pkg;

    localparam int VALUE_BITS  = 34;
    localparam int MAX_RESULTS = 4;
    localparam int INDEX_SPAN  = 4;
    localparam int RQ_DEPTH    = 8;
    localparam int RQ_PTR_BITS = 3;
    localparam int RQ_CNT_BITS = 4;

    localparam logic [1:0] KIND_WRITE_A = 2'd0;
    localparam logic [1:0] KIND_WRITE_B = 2'd1;
    localparam logic [1:0] KIND_CELL    = 2'd2;
    localparam logic [1:0] KIND_ROW     = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic [1:0]         row;
        logic [1:0]         col;
        logic signed [15:0] element;
    } req_item_t;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] product_value;
        logic [1:0]                   out_row;
        logic [1:0]                   out_col;
        logic                         last;
    } res_item_t;

    typedef struct packed {
        logic       valid;
        logic       first;
        logic       last_term;
        logic       done;
        logic [1:0] row;
        logic [1:0] col;
    } mac_tag_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } seq_state_t;

endpackage

// File: design/mme_store.sv
// Element memories for matrices A and B with one write and one registered read each.
module mme_store #(
    parameter int DEPTH     = 16,
    parameter int ADDR_BITS = 4,
    parameter int DATA_BITS = 16
) (
    input  logic                        clk,
    input  logic                        we_a,
    input  logic                        we_b,
    input  logic [ADDR_BITS-1:0]        waddr,
    input  logic signed [DATA_BITS-1:0] wdata,
    input  logic [ADDR_BITS-1:0]        raddr_a,
    input  logic [ADDR_BITS-1:0]        raddr_b,
    output logic signed [DATA_BITS-1:0] rdata_a,
    output logic signed [DATA_BITS-1:0] rdata_b
);

    logic signed [DATA_BITS-1:0] mem_a [DEPTH];
    logic signed [DATA_BITS-1:0] mem_b [DEPTH];
    logic signed [DATA_BITS-1:0] rdata_a_reg;
    logic signed [DATA_BITS-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we_a)
        begin
            mem_a[waddr] <= wdata;
        end
        rdata_a_reg <= mem_a[raddr_a];
    end

    always_ff @(posedge clk)
    begin
        if (we_b)
        begin
            mem_b[waddr] <= wdata;
        end
        rdata_b_reg <= mem_b[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// File: design/mme_mac.sv
// Multiply-accumulate pipeline that turns element pairs into finished dot products.
module mme_mac #(
    parameter int DATA_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mme_pkg::mac_tag_t           issue,
    input  logic signed [DATA_BITS-1:0] a_data,
    input  logic signed [DATA_BITS-1:0] b_data,
    output logic                        push,
    output mme_pkg::res_item_t          push_item
);

    import mme_pkg::*;

    localparam int PROD_BITS = 2 * DATA_BITS;

    mac_tag_t                     s1_tag_reg;
    mac_tag_t                     s2_tag_reg;
    logic signed [PROD_BITS-1:0]  prod_full;
    logic signed [VALUE_BITS-1:0] prod_fit;
    logic signed [VALUE_BITS-1:0] prod_reg;
    logic signed [VALUE_BITS-1:0] acc_reg;
    logic signed [VALUE_BITS-1:0] acc_next;

    assign prod_full = PROD_BITS'(a_data) * PROD_BITS'(b_data);

    generate
        if (PROD_BITS >= VALUE_BITS)
        begin : g_prod_trunc
            assign prod_fit = prod_full[VALUE_BITS-1:0];
        end
        else
        begin : g_prod_ext
            assign prod_fit = {{(VALUE_BITS-PROD_BITS){prod_full[PROD_BITS-1]}}, prod_full};
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg <= '0;
            s2_tag_reg <= '0;
        end
        else
        begin
            s1_tag_reg <= issue;
            s2_tag_reg <= s1_tag_reg;
        end
    end

    always_comb
    begin
        acc_next = s2_tag_reg.first ? prod_reg : acc_reg + prod_reg;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_fit;
        if (s2_tag_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    assign push                    = s2_tag_reg.valid & s2_tag_reg.last_term;
    assign push_item.product_value = acc_next;
    assign push_item.out_row       = s2_tag_reg.row;
    assign push_item.out_col       = s2_tag_reg.col;
    assign push_item.last          = s2_tag_reg.done;

endmodule

// File: design/mme_rq.sv
// Result queue that holds finished products until the output side takes them.
module mme_rq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  mme_pkg::res_item_t push_item,
    output logic               res_valid,
    input  logic               res_stall,
    output mme_pkg::res_item_t res_data
);

    import mme_pkg::*;

    res_item_t              entries [RQ_DEPTH];
    logic [RQ_PTR_BITS-1:0] wr_ptr_reg;
    logic [RQ_PTR_BITS-1:0] rd_ptr_reg;
    logic [RQ_CNT_BITS-1:0] count_reg;
    logic [RQ_CNT_BITS-1:0] count_next;
    logic                   pop;

    assign res_valid = (count_reg != '0);
    assign res_data  = entries[rd_ptr_reg];
    assign pop       = res_valid & ~res_stall;

    always_comb
    begin
        count_next = count_reg;
        if (push & ~pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop & ~push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: design/matrix_multiply_engine_top.sv
// Top level of the matrix multiply engine: request sequencer, memories, MAC and result queue.
//
//   Channel   Signals                           Carries
//   request   req_valid, req_stall, req_data    element writes, cell and row requests
//   result    res_valid, res_stall, res_data    product entries with row, column, last
//
// A write request goes straight to its memory. A cell request issues MATRIX_SIZE reads, a row
// request min(MATRIX_SIZE, 4) * MATRIX_SIZE reads, one pair a cycle through the shared
// multiply-accumulate unit; each product entry passes the registered read and product registers.
// Reset clears the control state only; the element memories hold no value until written.
// Every request waits while a compute request is issuing reads, and while the result queue
// has fewer than four places not yet reserved, four being the most results of a row request.
module matrix_multiply_engine_top #(
    parameter int MATRIX_SIZE  = 4,
    parameter int ELEMENT_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  mme_pkg::req_item_t req_data,
    output logic               res_valid,
    input  logic               res_stall,
    output mme_pkg::res_item_t res_data
);

    import mme_pkg::*;

    localparam int DEPTH     = MATRIX_SIZE * MATRIX_SIZE;
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int K_BITS    = (MATRIX_SIZE > 1) ? $clog2(MATRIX_SIZE) : 1;
    localparam int ROW_COLS  = (MATRIX_SIZE < INDEX_SPAN) ? MATRIX_SIZE : INDEX_SPAN;
    localparam logic [K_BITS-1:0]      K_LAST    = K_BITS'(MATRIX_SIZE - 1);
    localparam logic [1:0]             COL_LAST  = 2'(ROW_COLS - 1);
    localparam logic [RQ_CNT_BITS-1:0] RESV_MAX  = RQ_CNT_BITS'(RQ_DEPTH - MAX_RESULTS);
    localparam logic [RQ_CNT_BITS-1:0] ROW_COUNT = RQ_CNT_BITS'(ROW_COLS);

    seq_state_t             state_reg;
    seq_state_t             state_next;
    logic [1:0]             row_reg;
    logic [1:0]             row_next;
    logic [1:0]             col_reg;
    logic [1:0]             col_next;
    logic [1:0]             col_end_reg;
    logic [1:0]             col_end_next;
    logic [K_BITS-1:0]      k_reg;
    logic [K_BITS-1:0]      k_next;
    logic [RQ_CNT_BITS-1:0] resv_reg;
    logic [RQ_CNT_BITS-1:0] resv_next;
    logic [RQ_CNT_BITS-1:0] resv_add;

    logic                           req_accept;
    logic                           row_ok;
    logic                           col_ok;
    logic                           we_a;
    logic                           we_b;
    logic [ADDR_BITS-1:0]           waddr;
    logic signed [ELEMENT_BITS-1:0] wr_elem;
    logic [ADDR_BITS-1:0]           raddr_a;
    logic [ADDR_BITS-1:0]           raddr_b;
    logic signed [ELEMENT_BITS-1:0] rdata_a;
    logic signed [ELEMENT_BITS-1:0] rdata_b;
    mac_tag_t                       issue;
    logic                           push;
    res_item_t                      push_item;
    logic                           res_pop;

    assign req_stall  = (state_reg != ST_IDLE) || (resv_reg > RESV_MAX);
    assign req_accept = req_valid & ~req_stall;
    assign res_pop    = res_valid & ~res_stall;

    assign row_ok = (int'(req_data.row) < MATRIX_SIZE);
    assign col_ok = (int'(req_data.col) < MATRIX_SIZE);

    assign we_a  = req_accept && (req_data.kind == KIND_WRITE_A) && row_ok && col_ok;
    assign we_b  = req_accept && (req_data.kind == KIND_WRITE_B) && row_ok && col_ok;
    assign waddr = ADDR_BITS'(int'(req_data.row) * MATRIX_SIZE + int'(req_data.col));

    generate
        if (ELEMENT_BITS <= 16)
        begin : g_elem_trunc
            assign wr_elem = req_data.element[ELEMENT_BITS-1:0];
        end
        else
        begin : g_elem_ext
            assign wr_elem = {{(ELEMENT_BITS-16){req_data.element[15]}}, req_data.element};
        end
    endgenerate

    always_comb
    begin
        state_next   = state_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        col_end_next = col_end_reg;
        k_next       = k_reg;
        resv_add     = '0;
        issue        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_accept && row_ok)
                begin
                    if ((req_data.kind == KIND_CELL) && col_ok)
                    begin
                        state_next   = ST_RUN;
                        row_next     = req_data.row;
                        col_next     = req_data.col;
                        col_end_next = req_data.col;
                        k_next       = '0;
                        resv_add     = RQ_CNT_BITS'(1);
                    end
                    else if (req_data.kind == KIND_ROW)
                    begin
                        state_next   = ST_RUN;
                        row_next     = req_data.row;
                        col_next     = '0;
                        col_end_next = COL_LAST;
                        k_next       = '0;
                        resv_add     = ROW_COUNT;
                    end
                end
            end
            ST_RUN:
            begin
                issue.valid     = 1'b1;
                issue.first     = (k_reg == '0);
                issue.last_term = (k_reg == K_LAST);
                issue.done      = (k_reg == K_LAST) && (col_reg == col_end_reg);
                issue.row       = row_reg;
                issue.col       = col_reg;
                if (k_reg == K_LAST)
                begin
                    k_next = '0;
                    if (col_reg == col_end_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        resv_next = resv_reg + resv_add - RQ_CNT_BITS'(res_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            resv_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            resv_reg  <= resv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg     <= row_next;
        col_reg     <= col_next;
        col_end_reg <= col_end_next;
        k_reg       <= k_next;
    end

    assign raddr_a = ADDR_BITS'(int'(row_reg) * MATRIX_SIZE + int'(k_reg));
    assign raddr_b = ADDR_BITS'(int'(k_reg) * MATRIX_SIZE + int'(col_reg));

    mme_store #(
        .DEPTH     (DEPTH),
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS (ELEMENT_BITS)
    ) u_store (
        .clk     (clk),
        .we_a    (we_a),
        .we_b    (we_b),
        .waddr   (waddr),
        .wdata   (wr_elem),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    mme_mac #(
        .DATA_BITS (ELEMENT_BITS)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (issue),
        .a_data    (rdata_a),
        .b_data    (rdata_b),
        .push      (push),
        .push_item (push_item)
    );

    mme_rq u_rq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

endmodule
